@@ hdl/hsi_pkg.sv @@
// ----------------------------------------------------------------------------
// hsi_pkg
// Types, register codes and fault flag constants shared by the two-channel
// heater safety interlock.
// ----------------------------------------------------------------------------
package hsi_pkg;

	localparam int NUM_CH     = 2;
	localparam int MEAS_W     = 16;
	localparam int TIME_W     = 32;
	localparam int FLAG_W     = 5;
	localparam int DIS_W      = 3;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	// Sticky fault flag bits.
	localparam logic [FLAG_W-1:0] FLAG_OVERCURRENT = 5'h01;
	localparam logic [FLAG_W-1:0] FLAG_OVERTEMP    = 5'h02;
	localparam logic [FLAG_W-1:0] FLAG_OVERTIME    = 5'h04;
	localparam logic [FLAG_W-1:0] FLAG_UNDERTEMP   = 5'h08;
	localparam logic [FLAG_W-1:0] FLAG_CRC         = 5'h10;

	// More CRC failures than this since the baseline trip a running channel.
	localparam logic [TIME_W-1:0] CRC_FAIL_ALLOWANCE = 32'd1;

	// Per-channel disable bits.
	localparam int DIS_TEMP    = 0;
	localparam int DIS_CURRENT = 1;
	localparam int DIS_ONTIME  = 2;

	// Register indexes; register i sits at byte address 8*i.
	localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH_CH0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH_CH1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW_CH0     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW_CH1     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CURRENT_HIGH_CH0 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CURRENT_HIGH_CH1 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ON_TIME_LIMITS   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_DISABLES   = 3'd7;

	typedef struct packed {
		logic [NUM_CH-1:0][MEAS_W-1:0] temp_high;
		logic [NUM_CH-1:0][MEAS_W-1:0] temp_low;
		logic [NUM_CH-1:0][MEAS_W-1:0] current_high;
		logic [NUM_CH-1:0][TIME_W-1:0] on_time_limit;
		logic [NUM_CH*DIS_W-1:0]       check_disables;
	} cfg_t;

	typedef struct packed {
		logic signed [MEAS_W-1:0] temp_high;
		logic signed [MEAS_W-1:0] temp_low;
		logic signed [MEAS_W-1:0] current_high;
		logic [TIME_W-1:0]        on_time_limit;
		logic [DIS_W-1:0]         dis;
	} chan_cfg_t;

	typedef struct packed {
		logic                run_active;
		logic [TIME_W-1:0]   start_time;
		logic [FLAG_W-1:0]   faults;
	} chan_state_t;

	typedef struct packed {
		chan_state_t         state;
		logic [TIME_W-1:0]   baseline;
		logic                shut;
	} chan_upd_t;

endpackage

@@ hdl/hsi_if.sv @@
// ----------------------------------------------------------------------------
// hsi_sample_if / hsi_result_if
// Valid/ready channels carrying one sample set and one interlock result.
// ----------------------------------------------------------------------------
interface hsi_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_ch0;
	logic signed [15:0] temp_ch1;
	logic signed [15:0] current_ch0;
	logic signed [15:0] current_ch1;
	logic               drive_on_ch0;
	logic               drive_on_ch1;
	logic [31:0]        time_now;
	logic [31:0]        crc_fail_total;

	modport source (
		output valid, temp_ch0, temp_ch1, current_ch0, current_ch1,
		       drive_on_ch0, drive_on_ch1, time_now, crc_fail_total,
		input  ready
	);
	modport sink (
		input  valid, temp_ch0, temp_ch1, current_ch0, current_ch1,
		       drive_on_ch0, drive_on_ch1, time_now, crc_fail_total,
		output ready
	);
endinterface

interface hsi_result_if;
	logic       valid;
	logic       ready;
	logic       shut_ch0;
	logic       shut_ch1;
	logic [4:0] faults_ch0;
	logic [4:0] faults_ch1;

	modport source (
		output valid, shut_ch0, shut_ch1, faults_ch0, faults_ch1,
		input  ready
	);
	modport sink (
		input  valid, shut_ch0, shut_ch1, faults_ch0, faults_ch1,
		output ready
	);
endinterface

@@ hdl/hsi_cfg.sv @@
// ----------------------------------------------------------------------------
// hsi_cfg
// APB register file holding the limits and check disables.
// ----------------------------------------------------------------------------
module hsi_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hsi_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output hsi_pkg::cfg_t                  cfg
);
	import hsi_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_high      <= {NUM_CH{16'h7FFF}};
			cfg_q.temp_low       <= {NUM_CH{16'h8000}};
			cfg_q.current_high   <= {NUM_CH{16'h7FFF}};
			cfg_q.on_time_limit  <= '0;
			cfg_q.check_disables <= '1;
		end else if (wr_en) begin
			case (idx)
				REG_TEMP_HIGH_CH0:    cfg_q.temp_high[0]    <= pwdata[MEAS_W-1:0];
				REG_TEMP_HIGH_CH1:    cfg_q.temp_high[1]    <= pwdata[MEAS_W-1:0];
				REG_TEMP_LOW_CH0:     cfg_q.temp_low[0]     <= pwdata[MEAS_W-1:0];
				REG_TEMP_LOW_CH1:     cfg_q.temp_low[1]     <= pwdata[MEAS_W-1:0];
				REG_CURRENT_HIGH_CH0: cfg_q.current_high[0] <= pwdata[MEAS_W-1:0];
				REG_CURRENT_HIGH_CH1: cfg_q.current_high[1] <= pwdata[MEAS_W-1:0];
				REG_ON_TIME_LIMITS:   cfg_q.on_time_limit   <= pwdata;
				REG_CHECK_DISABLES:   cfg_q.check_disables  <= pwdata[NUM_CH*DIS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_TEMP_HIGH_CH0:    prdata = {48'd0, cfg_q.temp_high[0]};
			REG_TEMP_HIGH_CH1:    prdata = {48'd0, cfg_q.temp_high[1]};
			REG_TEMP_LOW_CH0:     prdata = {48'd0, cfg_q.temp_low[0]};
			REG_TEMP_LOW_CH1:     prdata = {48'd0, cfg_q.temp_low[1]};
			REG_CURRENT_HIGH_CH0: prdata = {48'd0, cfg_q.current_high[0]};
			REG_CURRENT_HIGH_CH1: prdata = {48'd0, cfg_q.current_high[1]};
			REG_ON_TIME_LIMITS:   prdata = cfg_q.on_time_limit;
			REG_CHECK_DISABLES:   prdata = {58'd0, cfg_q.check_disables};
			default:              prdata = '0;
		endcase
	end

endmodule

@@ hdl/hsi_chan.sv @@
// ----------------------------------------------------------------------------
// hsi_chan
// Checks of one heater channel: temperature window, current limit, on-time
// overrun and CRC failures since the shared baseline.
// ----------------------------------------------------------------------------
module hsi_chan (
	input  hsi_pkg::chan_cfg_t                   ccfg,
	input  hsi_pkg::chan_state_t                 state,
	input  logic [hsi_pkg::TIME_W-1:0]           baseline,
	input  logic signed [hsi_pkg::MEAS_W-1:0]    temp,
	input  logic signed [hsi_pkg::MEAS_W-1:0]    current,
	input  logic                                 drive_on,
	input  logic [hsi_pkg::TIME_W-1:0]           time_now,
	input  logic [hsi_pkg::TIME_W-1:0]           crc_total,
	output hsi_pkg::chan_upd_t                   upd
);
	import hsi_pkg::*;

	logic [FLAG_W-1:0] trip;
	logic [TIME_W-1:0] deadline;
	logic [TIME_W-1:0] crc_delta;

	// The deadline wraps at 32 bits and is compared without wrap awareness.
	assign deadline = state.start_time + ccfg.on_time_limit;

	always_comb begin
		trip         = '0;
		upd.state    = state;
		upd.baseline = baseline;

		if (!ccfg.dis[DIS_TEMP]) begin
			if (temp > ccfg.temp_high)
				trip = trip | FLAG_OVERTEMP;
			else if (temp < ccfg.temp_low)
				trip = trip | FLAG_UNDERTEMP;
		end
		if (!ccfg.dis[DIS_CURRENT] && (current > ccfg.current_high))
			trip = trip | FLAG_OVERCURRENT;

		if (!ccfg.dis[DIS_ONTIME]) begin
			if (drive_on) begin
				if (!state.run_active) begin
					upd.state.run_active = 1'b1;
					upd.state.start_time = time_now;
					upd.baseline         = crc_total;
				end else if (time_now >= deadline) begin
					trip = trip | FLAG_OVERTIME;
				end
			end else begin
				upd.state.run_active = 1'b0;
			end
		end

		crc_delta = crc_total - upd.baseline;
		if (drive_on && (crc_delta > CRC_FAIL_ALLOWANCE))
			trip = trip | FLAG_CRC;

		upd.state.faults = state.faults | trip;
		upd.shut         = |trip;
	end

endmodule

@@ hdl/two_channel_heater_safety_interlock.sv @@
// A transferred sample set is registered in stage one and its result in stage two.
// Throughput: one sample set per cycle; the input register and the result
// register form a two-stage pipeline, so a held result stops intake only once
// stage one is also full.
// Reset: arst_n clears the sticky faults, on-time tracking and CRC baseline,
// empties both stages and restores the register reset values.
// ----------------------------------------------------------------------------
// two_channel_heater_safety_interlock
// Applies temperature, current, on-time and CRC checks to two heater channels
// and reports per-sample shutdown pulses together with sticky fault flags.
// ----------------------------------------------------------------------------
module two_channel_heater_safety_interlock (
	input  logic                           clk,
	input  logic                           arst_n,
	hsi_sample_if.sink                     samples,
	hsi_result_if.source                   results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hsi_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import hsi_pkg::*;

	// Configuration registers.
	cfg_t cfg;

	hsi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage one: the transferred sample set is registered here unchanged.
	logic                     valid_s1;
	logic signed [MEAS_W-1:0] temp0_s1;
	logic signed [MEAS_W-1:0] temp1_s1;
	logic signed [MEAS_W-1:0] cur0_s1;
	logic signed [MEAS_W-1:0] cur1_s1;
	logic                     on0_s1;
	logic                     on1_s1;
	logic [TIME_W-1:0]        now_s1;
	logic [TIME_W-1:0]        crc_s1;

	// Stage two: the result register that drives the output channel.
	logic              valid_s2;
	logic              shut0_s2;
	logic              shut1_s2;
	logic [FLAG_W-1:0] faults0_s2;
	logic [FLAG_W-1:0] faults1_s2;

	// Interlock state carried from one sample set to the next.
	chan_state_t [NUM_CH-1:0] state_q;
	logic [TIME_W-1:0]        baseline_q;

	logic      advance;
	logic      take_in;
	chan_cfg_t ccfg0;
	chan_cfg_t ccfg1;
	chan_upd_t upd0;
	chan_upd_t upd1;

	// A sample set in stage one moves on whenever the result register is empty
	// or its result is being taken in this cycle; stage one refills at once.
	assign advance        = valid_s1 & (~valid_s2 | results.ready);
	assign samples.ready  = ~valid_s1 | advance;
	assign take_in        = samples.valid & samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			temp0_s1 <= samples.temp_ch0;
			temp1_s1 <= samples.temp_ch1;
			cur0_s1  <= samples.current_ch0;
			cur1_s1  <= samples.current_ch1;
			on0_s1   <= samples.drive_on_ch0;
			on1_s1   <= samples.drive_on_ch1;
			now_s1   <= samples.time_now;
			crc_s1   <= samples.crc_fail_total;
		end
	end

	// Per-channel views of the configuration.
	always_comb begin
		ccfg0.temp_high     = cfg.temp_high[0];
		ccfg0.temp_low      = cfg.temp_low[0];
		ccfg0.current_high  = cfg.current_high[0];
		ccfg0.on_time_limit = cfg.on_time_limit[0];
		ccfg0.dis           = cfg.check_disables[DIS_W-1:0];
		ccfg1.temp_high     = cfg.temp_high[1];
		ccfg1.temp_low      = cfg.temp_low[1];
		ccfg1.current_high  = cfg.current_high[1];
		ccfg1.on_time_limit = cfg.on_time_limit[1];
		ccfg1.dis           = cfg.check_disables[2*DIS_W-1:DIS_W];
	end

	// Channel 0 is checked first. A baseline it captures is already the one
	// channel 1 sees in the same sample set, hence the chained baseline.
	hsi_chan u_chan0 (
		.ccfg      (ccfg0),
		.state     (state_q[0]),
		.baseline  (baseline_q),
		.temp      (temp0_s1),
		.current   (cur0_s1),
		.drive_on  (on0_s1),
		.time_now  (now_s1),
		.crc_total (crc_s1),
		.upd       (upd0)
	);

	hsi_chan u_chan1 (
		.ccfg      (ccfg1),
		.state     (state_q[1]),
		.baseline  (upd0.baseline),
		.temp      (temp1_s1),
		.current   (cur1_s1),
		.drive_on  (on1_s1),
		.time_now  (now_s1),
		.crc_total (crc_s1),
		.upd       (upd1)
	);

	// State is committed in the same cycle as the result is registered, so
	// each sample set sees exactly what its predecessor left behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			baseline_q <= '0;
		end else if (advance) begin
			state_q[0] <= upd0.state;
			state_q[1] <= upd1.state;
			baseline_q <= upd1.baseline;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			shut0_s2   <= upd0.shut;
			shut1_s2   <= upd1.shut;
			faults0_s2 <= upd0.state.faults;
			faults1_s2 <= upd1.state.faults;
		end
	end

	assign results.valid      = valid_s2;
	assign results.shut_ch0   = shut0_s2;
	assign results.shut_ch1   = shut1_s2;
	assign results.faults_ch0 = faults0_s2;
	assign results.faults_ch1 = faults1_s2;

`ifndef ASSERT_OFF
	// Fault flags are sticky: no bit ever clears outside reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (((state_q[0].faults & $past(state_q[0].faults))
			== $past(state_q[0].faults))
			&& ((state_q[1].faults & $past(state_q[1].faults))
			== $past(state_q[1].faults))))
		else $error("sticky fault flag cleared");

	// A shutdown pulse always comes with at least one fault flag set.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((!shut0_s2 || (faults0_s2 != '0))
			&& (!shut1_s2 || (faults1_s2 != '0))))
		else $error("shutdown without a fault flag");

	// A sample set waiting behind a held result is not dropped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage one lost a sample set");

	// On-time tracking only starts on a channel whose on-time check is enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q[0].run_active) |-> !$past(cfg.check_disables[DIS_ONTIME]))
		else $error("channel 0 run started with on-time check disabled");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q[1].run_active)
			|-> !$past(cfg.check_disables[DIS_W+DIS_ONTIME]))
		else $error("channel 1 run started with on-time check disabled");
`endif

endmodule
